>>> rtl/core/tect_pkg.sv
// Package: shared constants and types of the trajectory exit crossing test.
`timescale 1ns / 1ps

package tect_pkg;

    localparam int DEF_MAX_SEGMENTS = 32;
    localparam int DEF_COORD_WIDTH  = 16;

    localparam int COUNT_WIDTH = 6;
    localparam int INDEX_WIDTH = 5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int STEP_WIDTH = 4;
    localparam logic [STEP_WIDTH-1:0] STEP_LAST = 4'd10;

    // sign of a difference of two products
    typedef struct packed {
        logic pos;
        logic zero;
    } sgn_t;

endpackage

>>> rtl/core/tect_orient_unit.sv
// Shared product unit: one multiply per cycle, signed compare of consecutive products.
`timescale 1ns / 1ps

module tect_orient_unit
    import tect_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
    input  logic                          clk,
    input  logic signed [COORD_WIDTH-1:0] lhs_a,
    input  logic signed [COORD_WIDTH-1:0] lhs_b,
    input  logic signed [COORD_WIDTH-1:0] rhs_a,
    input  logic signed [COORD_WIDTH-1:0] rhs_b,
    output sgn_t                          sign
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;

    logic signed [DIFF_W-1:0] lhs_diff;
    logic signed [DIFF_W-1:0] rhs_diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prev_reg;

    assign lhs_diff = DIFF_W'(lhs_a) - DIFF_W'(lhs_b);
    assign rhs_diff = DIFF_W'(rhs_a) - DIFF_W'(rhs_b);
    assign prod     = PROD_W'(lhs_diff) * PROD_W'(rhs_diff);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        prev_reg <= prod_reg;
    end

    // sign of (older product - newer product)
    assign sign.pos  = prev_reg > prod_reg;
    assign sign.zero = prev_reg == prod_reg;

endmodule

>>> rtl/core/trajectory_exit_crossing_test.sv
// Top level: segment table and sequencer for the trajectory exit crossing test.
//
//  channel   signals                                       transfer when
//  --------  --------------------------------------------  ------------------
//  item in   start, busy, operation, entry_index,          start && !busy
//            first_x, first_v, second_x, second_v
//  result    done, hit                                     done (one cycle)
//  config    cfg_we, cfg_wdata                             cfg_we
//
// A write item does not raise busy and gives no result. A query visits segments
// in order, each through table read, the shared product unit and a decision,
// and stops at the first exiting crossing.
// A query with a zero count answers on the next cycle.
// Reset clears the sequencer and segment_count; the table is not cleared.
// Results cannot be stalled; busy holds off new items during a query.
`timescale 1ns / 1ps

module trajectory_exit_crossing_test
    import tect_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [INDEX_WIDTH-1:0]        entry_index,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_v,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_v,
    output logic                          done,
    output logic                          hit,
    input  logic                          cfg_we,
    input  logic [COUNT_WIDTH-1:0]        cfg_wdata
);

    localparam int IDX_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int CMP_W   = CNT_W + COUNT_WIDTH;
    localparam int WIDX_W  = IDX_W + INDEX_WIDTH;
    localparam int ENTRY_W = 4 * COORD_WIDTH;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CALC = 4'b0100,
        ST_EVAL = 4'b1000
    } state_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    state_t                  state_reg, state_next;
    logic [STEP_WIDTH-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]        seg_idx_reg, seg_idx_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [COUNT_WIDTH-1:0]  segment_count_reg;
    logic                    done_reg, done_next;
    logic                    hit_reg, hit_next;

    coord_t ax_reg, av_reg, bx_reg, bv_reg;
    logic [ENTRY_W-1:0] segment_mem [MAX_SEGMENTS];
    logic [ENTRY_W-1:0] rd_reg;
    coord_t s0x, s0v, s1x, s1v;

    sgn_t sign_reg [5];
    sgn_t unit_sign;
    coord_t op_la, op_lb, op_ra, op_rb;

    logic              accept;
    logic [CMP_W-1:0]  cnt_ext, max_ext, n_sat;
    logic [WIDX_W-1:0] wr_idx;
    logic [CNT_W-1:0]  seg_idx_inc;
    logic              crossing, exiting, found;

    function automatic logic within_box(coord_t px, coord_t pv, coord_t qx, coord_t qv,
                                        coord_t rx, coord_t rv);
        logic in_x, in_v;
        in_x = (qx <= px || qx <= rx) && (qx >= px || qx >= rx);
        in_v = (qv <= pv || qv <= rv) && (qv >= pv || qv >= rv);
        return in_x && in_v;
    endfunction

    assign accept  = start && !busy;
    assign busy    = state_reg != ST_IDLE;
    assign done    = done_reg;
    assign hit     = hit_reg;

    assign cnt_ext = CMP_W'(segment_count_reg);
    assign max_ext = CMP_W'(MAX_SEGMENTS);
    assign n_sat   = (cnt_ext > max_ext) ? max_ext : cnt_ext;
    assign wr_idx  = WIDX_W'(entry_index);
    assign seg_idx_inc = seg_idx_reg + CNT_W'(1);

    assign {s0x, s0v, s1x, s1v} = rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            segment_count_reg <= cfg_wdata;
        end
    end

    // segment table
    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_WRITE && wr_idx < WIDX_W'(MAX_SEGMENTS))
        begin
            segment_mem[wr_idx[IDX_W-1:0]] <= {first_x, first_v, second_x, second_v};
        end
        rd_reg <= segment_mem[seg_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_QUERY)
        begin
            ax_reg <= first_x;
            av_reg <= first_v;
            bx_reg <= second_x;
            bv_reg <= second_v;
        end
    end

    // product schedule: pairs form o1, o2, o3, o4 and the direction term
    always_comb
    begin
        case (step_reg)
            4'd1:
            begin
                op_la = bx_reg; op_lb = ax_reg; op_ra = s0v;    op_rb = bv_reg;
            end
            4'd2:
            begin
                op_la = bv_reg; op_lb = av_reg; op_ra = s1x;    op_rb = bx_reg;
            end
            4'd3:
            begin
                op_la = bx_reg; op_lb = ax_reg; op_ra = s1v;    op_rb = bv_reg;
            end
            4'd4:
            begin
                op_la = s1v;    op_lb = s0v;    op_ra = ax_reg; op_rb = s1x;
            end
            4'd5:
            begin
                op_la = s1x;    op_lb = s0x;    op_ra = av_reg; op_rb = s1v;
            end
            4'd6:
            begin
                op_la = s1v;    op_lb = s0v;    op_ra = bx_reg; op_rb = s1x;
            end
            4'd7:
            begin
                op_la = s1x;    op_lb = s0x;    op_ra = bv_reg; op_rb = s1v;
            end
            4'd8:
            begin
                op_la = bx_reg; op_lb = ax_reg; op_ra = s1v;    op_rb = s0v;
            end
            4'd9:
            begin
                op_la = bv_reg; op_lb = av_reg; op_ra = s1x;    op_rb = s0x;
            end
            default:
            begin
                op_la = bv_reg; op_lb = av_reg; op_ra = s0x;    op_rb = bx_reg;
            end
        endcase
    end

    tect_orient_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_orient (
        .clk   (clk),
        .lhs_a (op_la),
        .lhs_b (op_lb),
        .rhs_a (op_ra),
        .rhs_b (op_rb),
        .sign  (unit_sign)
    );

    // a pair's sign is taken from the unit once its second product is in prod_reg, at the nonzero even steps
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC && !step_reg[0] && step_reg != '0)
        begin
            sign_reg[step_reg[3:1] - 3'd1] <= unit_sign;
        end
    end

    assign crossing = (sign_reg[0] != sign_reg[1] && sign_reg[2] != sign_reg[3])
        || (sign_reg[0].zero && within_box(ax_reg, av_reg, s0x, s0v, bx_reg, bv_reg))
        || (sign_reg[1].zero && within_box(ax_reg, av_reg, s1x, s1v, bx_reg, bv_reg))
        || (sign_reg[2].zero && within_box(s0x, s0v, ax_reg, av_reg, s1x, s1v))
        || (sign_reg[3].zero && within_box(s0x, s0v, bx_reg, bv_reg, s1x, s1v));
    assign exiting  = !sign_reg[4].pos;
    assign found    = crossing && exiting;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        seg_idx_next = seg_idx_reg;
        n_next       = n_reg;
        done_next    = 1'b0;
        hit_next     = hit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && operation == OP_QUERY)
                begin
                    seg_idx_next = '0;
                    n_next       = n_sat[CNT_W-1:0];
                    if (n_sat == '0)
                    begin
                        done_next = 1'b1;
                        hit_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                step_next  = '0;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                step_next = step_reg + STEP_WIDTH'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (found || seg_idx_inc == n_reg)
                begin
                    done_next  = 1'b1;
                    hit_next   = found;
                    state_next = ST_IDLE;
                end
                else
                begin
                    seg_idx_next = seg_idx_inc;
                    state_next   = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            seg_idx_reg <= '0;
            n_reg       <= '0;
            done_reg    <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            seg_idx_reg <= seg_idx_next;
            n_reg       <= n_next;
            done_reg    <= done_next;
            hit_reg     <= hit_next;
        end
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_EVAL) || ($past(start) && !$past(busy)))
        else $error("result without a query");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> seg_idx_reg < n_reg)
        else $error("segment index beyond count");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC |-> step_reg <= STEP_LAST)
        else $error("step counter overrun");

    a_no_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

endmodule

>>> dv/trajectory_exit_crossing_test_tb.sv
// Testbench for the trajectory exit crossing test: random table loads and step queries.
`timescale 1ns / 1ps

module trajectory_exit_crossing_test_tb;
    import tect_pkg::*;

    localparam int MAX_SEG     = DEF_MAX_SEGMENTS;
    localparam int CW          = DEF_COORD_WIDTH;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int IDLE_CYCLES = 16;
    localparam int END_CYCLES  = 420;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 90;

    typedef enum int {SPAN_FULL, SPAN_GRID, SPAN_MID, SPAN_CORNER} span_t;

    typedef struct {
        logic                   op;
        logic [INDEX_WIDTH-1:0] idx;
        logic signed [CW-1:0]   ax;
        logic signed [CW-1:0]   av;
        logic signed [CW-1:0]   bx;
        logic signed [CW-1:0]   bv;
    } item_t;

    typedef struct {
        longint x;
        longint v;
    } point_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   operation = OP_WRITE;
    logic [INDEX_WIDTH-1:0] entry_index = '0;
    logic signed [CW-1:0]   first_x = '0;
    logic signed [CW-1:0]   first_v = '0;
    logic signed [CW-1:0]   second_x = '0;
    logic signed [CW-1:0]   second_v = '0;
    logic                   done;
    logic                   hit;
    logic                   cfg_we = 1'b0;
    logic [COUNT_WIDTH-1:0] cfg_wdata = '0;

    item_t  pending[$];
    item_t  drv_item;
    bit     hit_expected[$];
    point_t seg_start[MAX_SEG];
    point_t seg_end[MAX_SEG];
    bit     seg_loaded[MAX_SEG];
    int     count_setting = 0;
    int     items_queued = 0;
    int     items_sent = 0;
    int     results_due = 0;
    int     results_seen = 0;
    int     mismatch_count = 0;
    int     burst_left = 1;
    int     gap_left = 0;
    bit     drain_hold = 1'b0;
    int     phase_counts[NUM_PHASES] = '{63, 2, 32, 1, 0, 5, 33, 3, 8, 4, 16, 1};

    trajectory_exit_crossing_test u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .entry_index(entry_index),
        .first_x    (first_x),
        .first_v    (first_v),
        .second_x   (second_x),
        .second_v   (second_v),
        .done       (done),
        .hit        (hit),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int sign_of(longint a);
        return (a > 0) ? 1 : ((a < 0) ? -1 : 0);
    endfunction

    function automatic int turn(point_t p, point_t q, point_t r);
        return sign_of((q.v - p.v) * (r.x - q.x) - (q.x - p.x) * (r.v - q.v));
    endfunction

    // q lies in the bounding box of p and r
    function automatic bit in_box(point_t p, point_t q, point_t r);
        return q.x <= ((p.x > r.x) ? p.x : r.x) && q.x >= ((p.x < r.x) ? p.x : r.x) &&
               q.v <= ((p.v > r.v) ? p.v : r.v) && q.v >= ((p.v < r.v) ? p.v : r.v);
    endfunction

    function automatic bit segments_meet(point_t p1, point_t q1, point_t p2, point_t q2);
        int o1;
        int o2;
        int o3;
        int o4;
        o1 = turn(p1, q1, p2);
        o2 = turn(p1, q1, q2);
        o3 = turn(p2, q2, p1);
        o4 = turn(p2, q2, q1);
        if (o1 != o2 && o3 != o4)
            return 1'b1;
        if (o1 == 0 && in_box(p1, p2, q1))
            return 1'b1;
        if (o2 == 0 && in_box(p1, q2, q1))
            return 1'b1;
        if (o3 == 0 && in_box(p2, p1, q2))
            return 1'b1;
        if (o4 == 0 && in_box(p2, q1, q2))
            return 1'b1;
        return 1'b0;
    endfunction

    // some counted segment is crossed while exiting; the search stops at the first one in table order
    function automatic bit exit_hit(item_t q);
        point_t a;
        point_t b;
        int     n;
        a.x = longint'(q.ax);
        a.v = longint'(q.av);
        b.x = longint'(q.bx);
        b.v = longint'(q.bv);
        n = (count_setting > MAX_SEG) ? MAX_SEG : count_setting;
        for (int i = 0; i < n; i++)
        begin
            if (segments_meet(a, b, seg_start[i], seg_end[i]) &&
                (b.x - a.x) * (seg_end[i].v - seg_start[i].v) -
                (b.v - a.v) * (seg_end[i].x - seg_start[i].x) <= 0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic signed [CW-1:0] pick_coord(span_t span);
        case (span)
            SPAN_FULL: return CW'($urandom);
            SPAN_GRID: return CW'(int'($urandom_range(0, 16)) - 8);
            SPAN_MID:  return CW'(int'($urandom_range(0, 4000)) - 2000);
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return CW'(-(2 ** (CW - 1)));
                    1:       return CW'(2 ** (CW - 1) - 1);
                    2:       return '0;
                    3:       return CW'(1);
                    4:       return CW'(-1);
                    default: return CW'(-(2 ** (CW - 1)) + 1);
                endcase
            end
        endcase
    endfunction

    function automatic void queue_item(input logic op, input int idx,
                                       input logic signed [CW-1:0] ax, av, bx, bv);
        item_t it;
        it.op  = op;
        it.idx = INDEX_WIDTH'(idx);
        it.ax  = ax;
        it.av  = av;
        it.bx  = bx;
        it.bv  = bv;
        pending.push_back(it);
        items_queued++;
        if (op == OP_WRITE)
            seg_loaded[idx] = 1'b1;
    endfunction

    function automatic void queue_random(span_t span, logic op, int idx);
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] av;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] bv;
        ax = pick_coord(span);
        av = pick_coord(span);
        bx = pick_coord(span);
        bv = pick_coord(span);
        if ($urandom_range(0, 19) == 0)
        begin
            bx = ax;
            bv = av;
        end
        queue_item(op, idx, ax, av, bx, bv);
    endfunction

    task automatic wait_idle();
        @(posedge clk);
        while (items_sent != items_queued || results_seen < results_due || busy)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(input int count);
        wait_idle();
        cfg_we        <= 1'b1;
        cfg_wdata     <= COUNT_WIDTH'(count);
        count_setting = count;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // driver: bursts of transfers with random gaps and occasional full drains
    always @(posedge clk)
    begin : driver
        bit launched_query;
        launched_query = 1'b0;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (drv_item.op == OP_WRITE)
                begin
                    seg_start[drv_item.idx].x = longint'(drv_item.ax);
                    seg_start[drv_item.idx].v = longint'(drv_item.av);
                    seg_end[drv_item.idx].x   = longint'(drv_item.bx);
                    seg_end[drv_item.idx].v   = longint'(drv_item.bv);
                end
                else
                begin
                    hit_expected.push_back(exit_hit(drv_item));
                    launched_query = 1'b1;
                end
                items_sent  <= items_sent + 1;
                results_due <= results_due + int'(launched_query);
            end
            if (!(start && busy))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (drain_hold && results_seen < results_due + int'(launched_query))
                begin
                    start <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    drain_hold  = 1'b0;
                    drv_item    = pending.pop_front();
                    operation   <= drv_item.op;
                    entry_index <= drv_item.idx;
                    first_x     <= drv_item.ax;
                    first_v     <= drv_item.av;
                    second_x    <= drv_item.bx;
                    second_v    <= drv_item.bv;
                    start       <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                        drain_hold = ($urandom_range(0, 15) == 0);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        if (rst_n && done)
        begin
            if (hit_expected.size() == 0)
            begin
                $error("hit: expected none, got %0b", hit);
                mismatch_count++;
            end
            else
            begin
                if (hit !== hit_expected[0])
                begin
                    $error("hit: expected %0b, got %0b", hit_expected[0], hit);
                    mismatch_count++;
                end
                void'(hit_expected.pop_front());
            end
            results_seen <= results_seen + 1;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("trajectory_exit_crossing_test test failed");
        $finish;
    end

    initial
    begin
        int    n;
        span_t span;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero count answers a miss without touching the table
        queue_item(OP_QUERY, 0, 0, 0, 100, 100);
        queue_item(OP_WRITE, 0, 0, -100, 0, 100);
        queue_item(OP_WRITE, 1, -32768, -32768, 32767, 32767);
        queue_item(OP_WRITE, 2, 500, 500, 500, 500);
        queue_item(OP_WRITE, 3, 2000, 0, 3000, 0);
        queue_item(OP_WRITE, 31, -32768, 32767, 32767, -32768);
        set_count(4);
        queue_item(OP_QUERY, 0, -50, 0, 50, 0);
        queue_item(OP_QUERY, 0, 50, 0, -50, 0);
        queue_item(OP_QUERY, 0, 0, 100, 10, 200);
        queue_item(OP_QUERY, 0, 0, 50, 0, 50);
        queue_item(OP_QUERY, 0, 400, 420, 600, 580);
        queue_item(OP_QUERY, 0, 2500, 0, 3500, 0);
        queue_item(OP_QUERY, 0, 3500, 0, 2500, 0);
        queue_item(OP_QUERY, 0, 4000, 0, 5000, 0);
        queue_item(OP_QUERY, 0, 2000, 1, 3000, 1);
        queue_item(OP_QUERY, 0, 32767, -32768, -32768, 32767);
        queue_item(OP_QUERY, 0, -32768, -32768, -32768, -32768);
        queue_item(OP_QUERY, 31, 3000, 0, 3000, 0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_count(phase_counts[p]);
            n    = (phase_counts[p] > MAX_SEG) ? MAX_SEG : phase_counts[p];
            span = span_t'($urandom_range(0, 3));
            for (int i = 0; i < n; i++)
            begin
                if (!seg_loaded[i])
                    queue_random(span, OP_WRITE, i);
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                queue_random(($urandom_range(0, 3) == 0) ? span_t'($urandom_range(0, 3)) : span,
                             ($urandom_range(0, 9) < 3) ? OP_WRITE : OP_QUERY,
                             $urandom_range(0, MAX_SEG - 1));
            end
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (hit_expected.size() != 0)
        begin
            $error("hit: expected %0b, got none", hit_expected[0]);
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("trajectory_exit_crossing_test test passed");
        else
            $display("trajectory_exit_crossing_test test failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/tect_pkg.sv
rtl/core/tect_orient_unit.sv
rtl/core/trajectory_exit_crossing_test.sv
dv/trajectory_exit_crossing_test_tb.sv
